// ===== hw/rtl/grc_pkg.sv =====
// shared constants, types and tables of the grid raycast column renderer
package grc_pkg;

    // screen, map and march geometry
    localparam int SCREEN_WIDTH  = 120;
    localparam int SCREEN_HEIGHT = 40;
    localparam int MAP_SIDE      = 16;
    localparam int MAX_STEPS     = 160;

    // angles in 4096 units per turn
    localparam int FOV_UNITS    = 512;
    localparam int HALF_FOV     = FOV_UNITS / 2;
    localparam int QUARTER_TURN = 1024;

    // ray coordinates are scaled by 10 * 16384 = 5 << 15
    localparam int COORD_SCALE = 163840;
    localparam int POS_SCALE   = 640;
    localparam int FRAC_SHIFT  = 15;
    localparam int DIV5_MUL    = 205;
    localparam int DIV5_SHIFT  = 10;

    // field widths
    localparam int COLUMN_W      = 7;
    localparam int POS_W         = 12;
    localparam int ANGLE_W       = 12;
    localparam int TRIG_W        = 16;
    localparam int ROW_FIELD_W   = 6;
    localparam int GLYPH_W       = 3;
    localparam int STEPS_FIELD_W = 8;
    localparam int OUT_FIELDS_W  = ROW_FIELD_W + GLYPH_W + STEPS_FIELD_W;
    localparam int IN_TDATA_W    = 48;
    localparam int OUT_TDATA_W   = 24;

    // configuration port
    localparam int CFG_INDEX_W  = 8;
    localparam int CFG_DATA_W   = 64;
    localparam int MAP_BITS     = 4 * CFG_DATA_W;
    localparam int MAP_ROW_BITS = 16;
    localparam int MAP_IDX_W    = $clog2(MAP_BITS);

    localparam logic [CFG_INDEX_W-1:0] REG_MAP_A = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_MAP_B = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_MAP_C = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_MAP_D = CFG_INDEX_W'(3);

    // internal widths
    localparam int STEP_W = $clog2(MAX_STEPS + 1);
    localparam int ROW_W  = $clog2(SCREEN_HEIGHT);
    localparam int TILE_W = $clog2(MAP_SIDE);
    localparam int Q_W    = $clog2(MAP_SIDE * 5);
    localparam int ACC_W  = $clog2(4095 * POS_SCALE + MAX_STEPS * 16384 + 1) + 1;
    localparam int NUM_W  = $clog2(SCREEN_HEIGHT * (MAX_STEPS + 20) + 1);
    localparam int DEN_W  = $clog2(2 * MAX_STEPS + 1);
    localparam int CEIL_W = NUM_W + 1;

    localparam logic signed [ACC_W-1:0] SCALE_NEG = ACC_W'(-COORD_SCALE);
    localparam logic signed [ACC_W-1:0] SCALE_END = ACC_W'(MAP_SIDE * COORD_SCALE);

    // glyph codes
    typedef logic [GLYPH_W-1:0] glyph_t;
    localparam glyph_t GLYPH_SPACE = 3'd0;
    localparam glyph_t GLYPH_BLOCK = 3'd1;
    localparam glyph_t GLYPH_HASH  = 3'd2;
    localparam glyph_t GLYPH_X     = 3'd3;
    localparam glyph_t GLYPH_DOT   = 3'd4;
    localparam glyph_t GLYPH_DASH  = 3'd5;

    // quarter-wave sine, Q1.14, 17 points
    typedef logic [14:0] sine_tab_t [0:16];
    localparam sine_tab_t QUARTER_SINE = '{
        15'd0, 15'd1606, 15'd3196, 15'd4756, 15'd6270, 15'd7723, 15'd9102, 15'd10394,
        15'd11585, 15'd12665, 15'd13623, 15'd14449, 15'd15137, 15'd15679, 15'd16069,
        15'd16305, 15'd16384
    };

    // angle offset of each screen column inside the field of view
    typedef logic [ANGLE_W-1:0] col_off_tab_t [0:(1 << COLUMN_W) - 1];

    function automatic col_off_tab_t build_col_off_tab();
        col_off_tab_t tab;
        for (int i = 0; i < (1 << COLUMN_W); i++)
        begin
            tab[i] = ANGLE_W'((i * FOV_UNITS) / SCREEN_WIDTH);
        end
        return tab;
    endfunction

    localparam col_off_tab_t COL_OFF_TAB = build_col_off_tab();

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SIN,
        ST_COS,
        ST_LOAD,
        ST_MARCH,
        ST_DIV,
        ST_EMIT
    } state_t;

    // control and status between sequencer and units
    typedef struct packed {
        logic                     start;
        logic [POS_W-1:0]         pos_x;
        logic [POS_W-1:0]         pos_y;
        logic signed [TRIG_W-1:0] rate_x;
        logic signed [TRIG_W-1:0] rate_y;
    } march_ctrl_t;

    typedef struct packed {
        logic              done;
        logic [STEP_W-1:0] steps;
    } march_stat_t;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } div_ctrl_t;

    typedef struct packed {
        logic                     done;
        logic signed [CEIL_W-1:0] quotient;
    } div_stat_t;

endpackage

// ===== hw/rtl/grc_march.sv =====
// ray march unit: one 0.1 tile step per cycle with map lookup
module grc_march (
    input  logic                          clk,
    input  logic                          rst_n,
    input  grc_pkg::march_ctrl_t          ctrl,
    input  logic [grc_pkg::MAP_BITS-1:0]  map_bits,
    output grc_pkg::march_stat_t          stat
);
    import grc_pkg::*;

    typedef struct packed {
        logic              outside;
        logic [TILE_W-1:0] idx;
    } tile_t;

    function automatic tile_t tile_of(input logic signed [ACC_W-1:0] scaled);
        tile_t            t;
        logic [Q_W-1:0]   q;
        logic [Q_W+7:0]   prod;
        t.outside = 1'b0;
        t.idx     = '0;
        q         = scaled[FRAC_SHIFT +: Q_W];
        // q / 5 by reciprocal, exact for q below 80
        prod      = (Q_W+8)'(q) * (Q_W+8)'(DIV5_MUL);
        if (scaled <= SCALE_NEG)
        begin
            t.outside = 1'b1;
        end
        else if (scaled < 0)
        begin
            t.idx = '0;
        end
        else if (scaled >= SCALE_END)
        begin
            t.outside = 1'b1;
        end
        else
        begin
            t.idx = TILE_W'(prod >> DIV5_SHIFT);
        end
        return t;
    endfunction

    logic                     busy_reg;
    logic                     done_reg;
    logic [STEP_W-1:0]        k_reg;
    logic [STEP_W-1:0]        steps_reg;
    logic signed [ACC_W-1:0]  acc_x_reg;
    logic signed [ACC_W-1:0]  acc_y_reg;
    logic signed [ACC_W-1:0]  rate_x_reg;
    logic signed [ACC_W-1:0]  rate_y_reg;

    tile_t                    tile_x;
    tile_t                    tile_y;
    logic [MAP_IDX_W-1:0]     map_idx;
    logic                     wall;

    assign tile_x  = tile_of(acc_x_reg);
    assign tile_y  = tile_of(acc_y_reg);
    assign map_idx = MAP_IDX_W'(tile_x.idx) * MAP_IDX_W'(MAP_ROW_BITS) + MAP_IDX_W'(tile_y.idx);
    assign wall    = map_bits[map_idx];

    assign stat.done  = done_reg;
    assign stat.steps = steps_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                k_reg    <= STEP_W'(1);
            end
            else if (busy_reg)
            begin
                if (tile_x.outside || tile_y.outside || wall || k_reg == STEP_W'(MAX_STEPS))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    k_reg <= k_reg + STEP_W'(1);
                end
            end
        end
    end

    // datapath: first step loaded at start, then one add per axis per cycle while busy
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            acc_x_reg  <= ACC_W'(ctrl.pos_x) * ACC_W'(POS_SCALE) + ACC_W'(ctrl.rate_x);
            acc_y_reg  <= ACC_W'(ctrl.pos_y) * ACC_W'(POS_SCALE) + ACC_W'(ctrl.rate_y);
            rate_x_reg <= ACC_W'(ctrl.rate_x);
            rate_y_reg <= ACC_W'(ctrl.rate_y);
        end
        else if (busy_reg)
        begin
            acc_x_reg <= acc_x_reg + rate_x_reg;
            acc_y_reg <= acc_y_reg + rate_y_reg;
            if (tile_x.outside || tile_y.outside)
            begin
                steps_reg <= STEP_W'(MAX_STEPS);
            end
            else
            begin
                steps_reg <= k_reg;
            end
        end
    end

endmodule

// ===== hw/rtl/grc_div.sv =====
// restoring divider for the ceiling row, one quotient bit per cycle
module grc_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  grc_pkg::div_ctrl_t   ctrl,
    output grc_pkg::div_stat_t   stat
);
    import grc_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam logic [NUM_W-1:0] OFFSET = NUM_W'(20 * SCREEN_HEIGHT);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                neg_reg;
    logic [NUM_W-1:0]    dvd_reg;
    logic [DEN_W-1:0]    den_reg;
    logic [DEN_W-1:0]    rem_reg;

    logic [NUM_W-1:0]    prod;
    logic [DEN_W:0]      shifted;
    logic                fits;

    assign prod    = NUM_W'(ctrl.steps) * NUM_W'(SCREEN_HEIGHT);
    assign shifted = {rem_reg, dvd_reg[NUM_W-1]};
    assign fits    = shifted >= {1'b0, den_reg};

    assign stat.done     = done_reg;
    assign stat.quotient = neg_reg ? -CEIL_W'(dvd_reg) : CEIL_W'(dvd_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            // sign and magnitude of H*n - 20*H, divisor 2n
            if (prod >= OFFSET)
            begin
                dvd_reg <= prod - OFFSET;
                neg_reg <= 1'b0;
            end
            else
            begin
                dvd_reg <= OFFSET - prod;
                neg_reg <= 1'b1;
            end
            den_reg <= DEN_W'(ctrl.steps) << 1;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= DEN_W'(shifted - {1'b0, den_reg});
            end
            else
            begin
                rem_reg <= DEN_W'(shifted);
            end
            dvd_reg <= {dvd_reg[NUM_W-2:0], fits};
        end
    end

endmodule

// ===== hw/rtl/grid_raycast_column_renderer.sv =====
// top level: one screen column per input beat, 40 glyph beats out
// first glyph: after accept, a column passes the sine, cosine, load, march and divide states
// column time: one column in flight; the next is accepted only after this one's last glyph
//   the march unit, at one step per cycle, sets the part that grows with the steps
// the ceiling divide and the 40 output beats set the rest
// reset: asynchronous, active low; map words clear to no walls, block returns to idle
module grid_raycast_column_renderer (
    input  logic                               clk,
    input  logic                               rst_n,
    // input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // column, pos_x, pos_y, heading, zero pad
    input  logic [grc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // output stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // row, glyph, hit_steps, zero pad
    output logic [grc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                               m_axis_tlast,
    // map register writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [grc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [grc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import grc_pkg::*;

    // piecewise linear sine over a quarter wave, Q1.14
    function automatic logic signed [TRIG_W-1:0] sine_q14(input logic [ANGLE_W-1:0] a);
        logic [1:0]  quad;
        logic [10:0] p;
        logic [3:0]  idx;
        logic [5:0]  frac;
        logic [14:0] base;
        logic [14:0] diff;
        logic [16:0] prod;
        logic [14:0] v;
        quad = a[ANGLE_W-1 -: 2];
        p    = {1'b0, a[ANGLE_W-3:0]};
        if (quad[0])
        begin
            p = 11'(QUARTER_TURN) - p;
        end
        idx  = p[9:6];
        frac = p[5:0];
        base = QUARTER_SINE[idx];
        diff = QUARTER_SINE[{1'b0, idx} + 5'd1] - base;
        prod = 17'(diff) * 17'(frac) + 17'd32;
        if (p[10])
        begin
            v = QUARTER_SINE[16];
        end
        else
        begin
            v = base + 15'(prod >> 6);
        end
        return quad[1] ? -TRIG_W'(v) : TRIG_W'(v);
    endfunction

    // glyph of one row given the ceiling row
    function automatic glyph_t glyph_of(input logic [ROW_W-1:0] y,
                                        input logic signed [CEIL_W-1:0] ceil);
        logic signed [CEIL_W+1:0] ys;
        logic signed [CEIL_W+1:0] cs;
        logic signed [CEIL_W+1:0] fl;
        logic [15:0]              rem;
        glyph_t                   g;
        ys  = (CEIL_W+2)'(y);
        cs  = (CEIL_W+2)'(ceil);
        fl  = (CEIL_W+2)'(SCREEN_HEIGHT) - cs;
        rem = 16'(SCREEN_HEIGHT) - 16'(y);
        if (ys < cs)
        begin
            g = GLYPH_SPACE;
        end
        else if (ys > cs && ys <= fl)
        begin
            g = GLYPH_BLOCK;
        end
        // floor shading bands; the ceiling row itself lands here too
        else if (rem * 16'd8 < 16'(SCREEN_HEIGHT))
        begin
            g = GLYPH_HASH;
        end
        else if (rem * 16'd4 < 16'(SCREEN_HEIGHT))
        begin
            g = GLYPH_X;
        end
        else if (rem * 16'd8 < 16'(3 * SCREEN_HEIGHT))
        begin
            g = GLYPH_DOT;
        end
        else if (rem * 16'd20 < 16'(9 * SCREEN_HEIGHT))
        begin
            g = GLYPH_DASH;
        end
        else
        begin
            g = GLYPH_SPACE;
        end
        return g;
    endfunction

    // sequencer
    state_t                   state_reg;
    state_t                   state_next;

    // map words
    logic [CFG_DATA_W-1:0]    map_a_reg;
    logic [CFG_DATA_W-1:0]    map_b_reg;
    logic [CFG_DATA_W-1:0]    map_c_reg;
    logic [CFG_DATA_W-1:0]    map_d_reg;
    logic [MAP_BITS-1:0]      map_bits;

    // column working registers
    logic [ANGLE_W-1:0]       angle_reg;
    logic [POS_W-1:0]         pos_x_reg;
    logic [POS_W-1:0]         pos_y_reg;
    logic signed [TRIG_W-1:0] rate_x_reg;
    logic signed [TRIG_W-1:0] rate_y_reg;
    logic [STEP_W-1:0]        steps_reg;
    logic signed [CEIL_W-1:0] ceil_reg;
    logic [ROW_W-1:0]         row_reg;
    glyph_t                   glyph_reg;

    // input beat fields
    logic [COLUMN_W-1:0]      in_column;
    logic [POS_W-1:0]         in_pos_x;
    logic [POS_W-1:0]         in_pos_y;
    logic [ANGLE_W-1:0]       in_heading;

    logic                     in_beat;
    logic                     out_beat;
    logic                     last_row;
    logic [ANGLE_W-1:0]       trig_arg;
    logic signed [TRIG_W-1:0] trig_val;

    march_ctrl_t              march_ctrl;
    march_stat_t              march_stat;
    div_ctrl_t                div_ctrl;
    div_stat_t                div_stat;

    assign in_column  = s_axis_tdata[0 +: COLUMN_W];
    assign in_pos_x   = s_axis_tdata[COLUMN_W +: POS_W];
    assign in_pos_y   = s_axis_tdata[COLUMN_W + POS_W +: POS_W];
    assign in_heading = s_axis_tdata[COLUMN_W + 2 * POS_W +: ANGLE_W];

    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign out_beat = m_axis_tvalid && m_axis_tready;
    assign last_row = row_reg == ROW_W'(SCREEN_HEIGHT - 1);

    // one trig evaluator, sine first then cosine as sine a quarter turn ahead
    assign trig_arg = (state_reg == ST_SIN) ? angle_reg : angle_reg + ANGLE_W'(QUARTER_TURN);
    assign trig_val = sine_q14(trig_arg);

    assign map_bits = {map_d_reg, map_c_reg, map_b_reg, map_a_reg};

    assign march_ctrl.start  = state_reg == ST_LOAD;
    assign march_ctrl.pos_x  = pos_x_reg;
    assign march_ctrl.pos_y  = pos_y_reg;
    assign march_ctrl.rate_x = rate_x_reg;
    assign march_ctrl.rate_y = rate_y_reg;

    assign div_ctrl.start = (state_reg == ST_MARCH) && march_stat.done;
    assign div_ctrl.steps = march_stat.steps;

    assign m_axis_tdata = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
                           STEPS_FIELD_W'(steps_reg), glyph_reg, ROW_FIELD_W'(row_reg)};
    assign m_axis_tlast = last_row;

    // map words are only written while the block is idle
    assign cfg_ready = state_reg == ST_IDLE;

    grc_march u_march (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (march_ctrl),
        .map_bits (map_bits),
        .stat     (march_stat)
    );

    grc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (div_ctrl),
        .stat  (div_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    state_next = ST_SIN;
                end
            end
            ST_SIN:
            begin
                state_next = ST_COS;
            end
            ST_COS:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                state_next = ST_MARCH;
            end
            ST_MARCH:
            begin
                if (march_stat.done)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready && last_row)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // map register writes, unknown indexes dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_a_reg <= '0;
            map_b_reg <= '0;
            map_c_reg <= '0;
            map_d_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MAP_A: map_a_reg <= cfg_data;
                REG_MAP_B: map_b_reg <= cfg_data;
                REG_MAP_C: map_c_reg <= cfg_data;
                REG_MAP_D: map_d_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    // column datapath
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            // heading - fov/2 + column offset, wrapping once per turn
            angle_reg <= in_heading - ANGLE_W'(HALF_FOV) + COL_OFF_TAB[in_column];
            pos_x_reg <= in_pos_x;
            pos_y_reg <= in_pos_y;
        end
        if (state_reg == ST_SIN)
        begin
            rate_x_reg <= trig_val;
        end
        if (state_reg == ST_COS)
        begin
            rate_y_reg <= trig_val;
        end
        if (div_ctrl.start)
        begin
            steps_reg <= march_stat.steps;
        end
        if (state_reg == ST_DIV && div_stat.done)
        begin
            ceil_reg  <= div_stat.quotient;
            row_reg   <= '0;
            glyph_reg <= glyph_of('0, div_stat.quotient);
        end
        else if (out_beat && !last_row)
        begin
            row_reg   <= row_reg + ROW_W'(1);
            glyph_reg <= glyph_of(row_reg + ROW_W'(1), ceil_reg);
        end
    end

endmodule

// ===== hw/rtl/grc_checker.sv =====
// port-level checks of the column renderer and their bind
module grc_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    input  logic                               s_axis_tready,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic [grc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                               m_axis_tlast
);
    import grc_pkg::*;

    logic out_beat;

    assign out_beat = m_axis_tvalid && m_axis_tready;

    // no new column is taken while glyph beats are pending
    a_busy_while_emitting: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while output beats pending");

    // the column ends after its last beat
    a_end_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_beat && m_axis_tlast) |=> !m_axis_tvalid)
        else $error("output valid after last beat");

    // rows come out in order with no gap
    a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_beat && !m_axis_tlast) |=> (m_axis_tvalid &&
            m_axis_tdata[ROW_FIELD_W-1:0] ==
            $past(m_axis_tdata[ROW_FIELD_W-1:0]) + ROW_FIELD_W'(1)))
        else $error("row sequence broken");

    // step count is the same for every row of a column
    a_steps_steady: assert property (@(posedge clk) disable iff (!rst_n)
        (out_beat && !m_axis_tlast) |=>
            $stable(m_axis_tdata[ROW_FIELD_W + GLYPH_W +: STEPS_FIELD_W]))
        else $error("hit steps changed within a column");

    // a stalled beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled output beat changed");

endmodule

bind grid_raycast_column_renderer grc_checker u_grc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/sv/grc_column_checker.sv =====
`timescale 1ns / 100ps
// checker: predicts the glyph beats of every accepted column and compares the output stream
module grc_column_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    input  logic                               s_axis_tready,
    // column, pos_x, pos_y, heading, zero pad
    input  logic [grc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // row, glyph, hit_steps, zero pad
    input  logic [grc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                               m_axis_tlast,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [grc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [grc_pkg::CFG_DATA_W-1:0]     cfg_data,
    output int                                 mismatches,
    output int                                 pending
);

    localparam int     ROWS      = grc_pkg::SCREEN_HEIGHT;
    localparam int     STEP_MAX  = grc_pkg::MAX_STEPS;
    localparam int     SIDE      = grc_pkg::MAP_SIDE;
    localparam longint RAY_SCALE = 163840;

    typedef struct packed {
        logic [5:0]       row;
        grc_pkg::glyph_t  glyph;
        logic [7:0]       steps;
        logic             last;
    } glyph_beat_t;

    glyph_beat_t expected_glyphs [$];
    logic [63:0] wall_words [0:3];

    // sin(k*pi/32) in Q1.14
    function automatic int quarter_wave(input int unsigned k);
        case (k)
            0:       return 0;
            1:       return 1606;
            2:       return 3196;
            3:       return 4756;
            4:       return 6270;
            5:       return 7723;
            6:       return 9102;
            7:       return 10394;
            8:       return 11585;
            9:       return 12665;
            10:      return 13623;
            11:      return 14449;
            12:      return 15137;
            13:      return 15679;
            14:      return 16069;
            15:      return 16305;
            default: return 16384;
        endcase
    endfunction

    function automatic int sine_q14(input int unsigned a);
        int unsigned quad;
        int unsigned p;
        int unsigned idx;
        int          frac;
        int          diff;
        int          v;
        quad = (a & 4095) >> 10;
        p    = a & 1023;
        if (quad[0])
            p = 1024 - p;
        if ((p >> 6) >= 16)
            v = 16384;
        else
        begin
            idx  = p >> 6;
            frac = int'(p & 63);
            diff = quarter_wave(idx + 1) - quarter_wave(idx);
            v    = quarter_wave(idx) + ((diff * frac + 32) >>> 6);
        end
        return (quad >= 2) ? -v : v;
    endfunction

    // -1 marks a coordinate off the map; (-1, 0) tiles still counts as tile 0
    function automatic int tile_index(input longint scaled);
        longint t;
        if (scaled <= -RAY_SCALE)
            return -1;
        if (scaled < 0)
            return 0;
        t = scaled / RAY_SCALE;
        if (t >= SIDE)
            return -1;
        return int'(t);
    endfunction

    function automatic logic wall_at(input int r, input int c);
        return wall_words[r >> 2][(r % 4) * 16 + c];
    endfunction

    function automatic int march_steps(input logic [6:0] col, input logic [11:0] px,
                                       input logic [11:0] py, input logic [11:0] hd);
        longint      base_x;
        longint      base_y;
        longint      rate_x;
        longint      rate_y;
        int unsigned ang;
        int          tr;
        int          tc;
        base_x = longint'(px) * 640;
        base_y = longint'(py) * 640;
        ang    = (32'(hd) + 4096 - 256 + (32'(col) * 512) / 120) & 4095;
        rate_x = sine_q14(ang);
        rate_y = sine_q14(ang + 1024);
        for (int k = 1; k <= STEP_MAX; k++)
        begin
            tr = tile_index(base_x + rate_x * k);
            tc = tile_index(base_y + rate_y * k);
            if (tr < 0 || tc < 0)
                return STEP_MAX;
            if (wall_at(tr, tc))
                return k;
        end
        return STEP_MAX;
    endfunction

    function automatic grc_pkg::glyph_t row_glyph(input int y, input int ceil_row);
        int floor_row;
        int rem;
        floor_row = ROWS - ceil_row;
        rem       = ROWS - y;
        if (y < ceil_row)
            return grc_pkg::GLYPH_SPACE;
        else if (y > ceil_row && y <= floor_row)
            return grc_pkg::GLYPH_BLOCK;
        else if (8 * rem < ROWS)
            return grc_pkg::GLYPH_HASH;
        else if (4 * rem < ROWS)
            return grc_pkg::GLYPH_X;
        else if (8 * rem < 3 * ROWS)
            return grc_pkg::GLYPH_DOT;
        else if (20 * rem < 9 * ROWS)
            return grc_pkg::GLYPH_DASH;
        else
            return grc_pkg::GLYPH_SPACE;
    endfunction

    task automatic predict_column(input logic [grc_pkg::IN_TDATA_W-1:0] beat_data);
        int          n;
        int          ceil_row;
        glyph_beat_t exp_beat;
        n = march_steps(beat_data[6:0], beat_data[18:7], beat_data[30:19], beat_data[42:31]);
        ceil_row = (ROWS * n - 20 * ROWS) / (2 * n);
        for (int y = 0; y < ROWS; y++)
        begin
            exp_beat.row   = 6'(y);
            exp_beat.glyph = row_glyph(y, ceil_row);
            exp_beat.steps = 8'(n);
            exp_beat.last  = (y == ROWS - 1);
            expected_glyphs.push_back(exp_beat);
        end
    endtask

    task automatic compare_beat();
        glyph_beat_t exp_beat;
        if (expected_glyphs.size() == 0)
        begin
            $error("output beat with no column pending: tdata %h", m_axis_tdata);
            mismatches++;
        end
        else
        begin
            exp_beat = expected_glyphs.pop_front();
            if (m_axis_tdata[5:0] !== exp_beat.row)
            begin
                $error("row: expected %0d, actual %0d", exp_beat.row, m_axis_tdata[5:0]);
                mismatches++;
            end
            if (m_axis_tdata[8:6] !== exp_beat.glyph)
            begin
                $error("glyph: expected %0d, actual %0d", exp_beat.glyph, m_axis_tdata[8:6]);
                mismatches++;
            end
            if (m_axis_tdata[16:9] !== exp_beat.steps)
            begin
                $error("hit_steps: expected %0d, actual %0d", exp_beat.steps,
                       m_axis_tdata[16:9]);
                mismatches++;
            end
            if (m_axis_tlast !== exp_beat.last)
            begin
                $error("last: expected %0d, actual %0d", exp_beat.last, m_axis_tlast);
                mismatches++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int q = 0; q < 4; q++)
                wall_words[q] = '0;
            expected_glyphs.delete();
            mismatches = 0;
            pending    = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready && cfg_index <= grc_pkg::REG_MAP_D)
                wall_words[cfg_index[1:0]] = cfg_data;
            if (m_axis_tvalid && m_axis_tready)
                compare_beat();
            if (s_axis_tvalid && s_axis_tready)
                predict_column(s_axis_tdata);
            pending = expected_glyphs.size();
        end
    end

endmodule

// ===== tb/sv/tb_grid_raycast_column_renderer.sv =====
`timescale 1ns / 100ps
// testbench top: drives columns and map writes into the raycaster and reports the verdict
module tb_grid_raycast_column_renderer;

    // idle cycles after the last expected beat, above the worst march plus divide
    localparam int DRAIN_CYCLES = 250;
    // receiver hold-off long enough to back the block up into its input
    localparam int HOLD_CYCLES  = 600;
    localparam int LIMIT_CYCLES = 500000;
    localparam int IDLE_PCT     = 22;

    // an index beyond the four map words, writes to it must be dropped
    localparam logic [grc_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED = 8'd9;

    // map plans
    localparam int MAP_BORDER_SPARSE = 0;
    localparam int MAP_OPEN_ROOM     = 1;
    localparam int MAP_SOLID         = 2;
    localparam int MAP_NOISE         = 3;

    logic                               clk           = 1'b0;
    logic                               rst_n         = 1'b0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    // column, pos_x, pos_y, heading, zero pad
    logic [grc_pkg::IN_TDATA_W-1:0]     s_axis_tdata  = '0;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    // row, glyph, hit_steps, zero pad
    logic [grc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata;
    logic                               m_axis_tlast;
    logic                               cfg_valid     = 1'b0;
    logic                               cfg_ready;
    logic [grc_pkg::CFG_INDEX_W-1:0]    cfg_index     = '0;
    logic [grc_pkg::CFG_DATA_W-1:0]     cfg_data      = '0;

    int   mismatches;
    int   pending;
    int   cycle_count = 0;

    // random idling per side, and a one-shot request for a long receiver stall
    bit   tx_idle_on  = 1'b1;
    bit   rx_idle_on  = 1'b1;
    bit   hold_start  = 1'b0;

    // wall rows as planned here, packed four per register on write
    logic [15:0] map_plan [0:15];

    grid_raycast_column_renderer uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    grc_column_checker u_column_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // run limit, generous against the slowest legal run
    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[grid_raycast_column_renderer] ERROR");
        $finish;
    end

    // output side: random back-pressure, plus the long hold-off when requested
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_start)
            begin
                hold_start = 1'b0;
                repeat (HOLD_CYCLES)
                begin
                    m_axis_tready <= 1'b0;
                    @(negedge clk);
                end
            end
            m_axis_tready <= !(rx_idle_on && ($urandom_range(99) < IDLE_PCT));
        end
    end

    // one column beat; valid stays high afterwards so beats can go back to back
    task automatic send_column(input logic [6:0] col, input logic [11:0] px,
                               input logic [11:0] py, input logic [11:0] hd);
        @(negedge clk);
        while (tx_idle_on && ($urandom_range(99) < IDLE_PCT))
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, hd, py, px, col};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // mostly on-screen columns, a few past the right edge to exercise angle wrap
    task automatic send_random_column();
        logic [6:0] col;
        if ($urandom_range(9) == 0)
            col = 7'($urandom_range(127, 120));
        else
            col = 7'($urandom_range(119));
        send_column(col, 12'($urandom), 12'($urandom), 12'($urandom));
    endtask

    // drop valid, wait out every expected beat, then let the block settle
    task automatic drain_columns();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [grc_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [grc_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // build a wall map and load all four map words
    task automatic plan_map(input int kind);
        logic [15:0] interior;
        for (int r = 0; r < 16; r++)
        begin
            case (kind)
                MAP_SOLID:
                    map_plan[r] = 16'hFFFF;
                MAP_NOISE:
                    map_plan[r] = 16'($urandom);
                default:
                begin
                    // about one interior wall in eight for the sparse plan
                    interior = (kind == MAP_BORDER_SPARSE) ?
                               16'($urandom & $urandom & $urandom) : 16'h0000;
                    if (r == 0 || r == 15)
                        map_plan[r] = 16'hFFFF;
                    else
                        map_plan[r] = 16'h8001 | (interior & 16'h7FFE);
                end
            endcase
        end
        for (int q = 0; q < 4; q++)
        begin
            write_reg(grc_pkg::REG_MAP_A + grc_pkg::CFG_INDEX_W'(q),
                      {map_plan[4 * q + 3], map_plan[4 * q + 2],
                       map_plan[4 * q + 1], map_plan[4 * q]});
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty map after reset: every ray runs off the map or out of steps
        send_column(7'd0, 12'd0, 12'd0, 12'd0);           // slightly negative first step
        send_column(7'd119, 12'd4095, 12'd4095, 12'd4095);
        send_column(7'd127, 12'd2048, 12'd2048, 12'd2048); // past the screen edge
        send_column(7'd60, 12'd128, 12'd128, 12'd512);     // diagonal stays inside, no wall
        send_column(7'd1, 12'd2048, 12'd0, 12'd2048);
        drain_columns();

        // walled border with sparse interior
        plan_map(MAP_BORDER_SPARSE);
        send_column(7'd60, 12'd128, 12'd128, 12'd0);       // standing in a wall tile
        send_column(7'd60, 12'd2048, 12'd2048, 12'd0);
        send_column(7'd60, 12'd2048, 12'd2048, 12'd1024);
        send_column(7'd60, 12'd2048, 12'd2048, 12'd2048);
        send_column(7'd60, 12'd2048, 12'd2048, 12'd3072);
        send_column(7'd0, 12'd300, 12'd300, 12'd3072);     // close to the border
        send_column(7'd119, 12'd3800, 12'd3800, 12'd1000);
        send_column(7'd120, 12'd1500, 12'd2600, 12'd700);
        send_column(7'd127, 12'd4095, 12'd0, 12'd4095);
        send_column(7'd30, 12'd0, 12'd4095, 12'd1536);
        repeat (40) send_random_column();
        drain_columns();

        // solid map, then a write to an unmapped index that must change nothing
        plan_map(MAP_SOLID);
        send_column(7'd0, 12'd0, 12'd0, 12'd0);
        send_column(7'd119, 12'd4095, 12'd4095, 12'd4095);
        drain_columns();
        write_reg(REG_UNMAPPED, 64'h0);
        send_column(7'd64, 12'd2048, 12'd2048, 12'd2048);
        drain_columns();

        // noisy map; first stretch with no idling on either side
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        plan_map(MAP_NOISE);
        repeat (40) send_random_column();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        repeat (20) send_random_column();
        drain_columns();

        plan_map(MAP_BORDER_SPARSE);
        repeat (42) send_random_column();
        drain_columns();

        // open room gives the longest marches; stall the output mid-way
        plan_map(MAP_OPEN_ROOM);
        for (int i = 0; i < 50; i++)
        begin
            if (i == 10)
                hold_start = 1'b1;
            send_random_column();
        end
        drain_columns();

        if (mismatches == 0 && pending == 0)
            $display("[grid_raycast_column_renderer] OK");
        else
            $display("[grid_raycast_column_renderer] ERROR");
        $finish;
    end

endmodule
